// File: hdl/itc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval timer channel package
// Types, codes and helper functions shared by the timer channel files.
// ----------------------------------------------------------------------------
package itc_pkg;

    typedef logic [1:0]  cmd_t;
    typedef logic [7:0]  byte_t;
    typedef logic [15:0] count_t;
    typedef logic [1:0]  mode_t;
    typedef logic [1:0]  acc_t;

    localparam cmd_t CMD_TICK     = 2'd0;
    localparam cmd_t CMD_WR_CTRL  = 2'd1;
    localparam cmd_t CMD_WR_COUNT = 2'd2;
    localparam cmd_t CMD_RD_COUNT = 2'd3;

    localparam acc_t ACC_LATCH = 2'd0;
    localparam acc_t ACC_LO    = 2'd1;
    localparam acc_t ACC_HI    = 2'd2;
    localparam acc_t ACC_LOHI  = 2'd3;

    localparam mode_t MODE_ONESHOT = 2'd0;
    localparam mode_t MODE_RATE    = 2'd2;
    localparam mode_t MODE_SQUARE  = 2'd3;

    localparam count_t COUNT_ONE = 16'd1;
    localparam count_t COUNT_TWO = 16'd2;

    function automatic mode_t mode_decode(logic [2:0] m);
        mode_t r;
        unique case (m)
            3'd2, 3'd6: r = MODE_RATE;
            3'd3, 3'd7: r = MODE_SQUARE;
            default:    r = MODE_ONESHOT;
        endcase
        return r;
    endfunction

    // Count loaded at the start of a square-wave half period.
    function automatic count_t half_period_load(count_t n, logic level);
        count_t r;
        if (!n[0])
            r = n;
        else if (level)
            r = n + COUNT_ONE;
        else if (n == COUNT_ONE)
            r = COUNT_TWO;
        else
            r = n - COUNT_ONE;
        return r;
    endfunction

endpackage

// File: hdl/itc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval timer channel interfaces
// Request and response channels with a valid and ready handshake per beat.
// ----------------------------------------------------------------------------
interface itc_req_if import itc_pkg::*; ();
    logic  valid;
    logic  ready;
    cmd_t  cmd;
    byte_t data_byte;

    modport source(output valid, output cmd, output data_byte, input ready);
    modport sink(input valid, input cmd, input data_byte, output ready);
endinterface

interface itc_rsp_if import itc_pkg::*; ();
    logic   valid;
    logic   ready;
    byte_t  read_byte;
    logic   out_level;
    count_t current_count;

    modport source(output valid, output read_byte, output out_level,
                   output current_count, input ready);
    modport sink(input valid, input read_byte, input out_level,
                 input current_count, output ready);
endinterface

// File: hdl/interval_timer_channel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval timer channel
// One 8254-style counter channel driven by tick, command, write and read beats.
// ----------------------------------------------------------------------------
// Path: a request beat passes the input register, then the result register, to
// become a response beat; the channel state is updated in the same single pass.
// Throughput: one beat per cycle; the result register and the input register
// keep moving as long as the response side takes beats.
// Reset: asynchronous, active low; the counter is stopped at zero, OUT is high
// and access is low byte then high byte.
module interval_timer_channel_top import itc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    itc_req_if.sink   req,
    itc_rsp_if.source rsp
);

    logic   s1_valid_reg;
    cmd_t   s1_cmd_reg;
    byte_t  s1_data_reg;
    logic   s1_fire;

    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    byte_t  rsp_read_byte_reg;
    logic   rsp_out_level_reg;
    count_t rsp_count_reg;

    count_t count_reg,       count_next;
    count_t reload_reg,      reload_next;
    mode_t  mode_reg,        mode_next;
    acc_t   access_kind_reg, access_kind_next;
    byte_t  low_pending_reg, low_pending_next;
    logic   write_toggle_reg, write_toggle_next;
    logic   read_toggle_reg,  read_toggle_next;
    count_t latched_reg,     latched_next;
    logic   latch_held_reg,  latch_held_next;
    logic   running_reg,     running_next;
    logic   out_pin_reg,     out_pin_next;

    byte_t  rd_byte;
    logic   do_load;
    count_t dec1;
    count_t rd_src;

    assign s1_fire   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_byte     = rsp_read_byte_reg;
    assign rsp.out_level     = rsp_out_level_reg;
    assign rsp.current_count = rsp_count_reg;

    assign dec1   = count_reg - COUNT_ONE;
    assign rd_src = latch_held_reg ? latched_reg : count_reg;

    always_comb
    begin
        count_next        = count_reg;
        reload_next       = reload_reg;
        mode_next         = mode_reg;
        access_kind_next  = access_kind_reg;
        low_pending_next  = low_pending_reg;
        write_toggle_next = write_toggle_reg;
        read_toggle_next  = read_toggle_reg;
        latched_next      = latched_reg;
        latch_held_next   = latch_held_reg;
        running_next      = running_reg;
        out_pin_next      = out_pin_reg;
        rd_byte           = '0;
        do_load           = 1'b0;

        unique case (s1_cmd_reg)
            CMD_TICK:
            begin
                if (running_reg)
                begin
                    if (mode_reg == MODE_RATE)
                    begin
                        if (count_reg == COUNT_ONE)
                        begin
                            count_next   = reload_reg;
                            out_pin_next = 1'b1;
                        end
                        else
                        begin
                            count_next = dec1;
                            if (dec1 == COUNT_ONE)
                                out_pin_next = 1'b0;
                        end
                    end
                    else if (mode_reg == MODE_SQUARE)
                    begin
                        if (count_reg == COUNT_TWO)
                        begin
                            out_pin_next = !out_pin_reg;
                            count_next   = half_period_load(reload_reg, !out_pin_reg);
                        end
                        else
                            count_next = count_reg - COUNT_TWO;
                    end
                    else
                    begin
                        count_next = dec1;
                        if (dec1 == '0)
                            out_pin_next = 1'b1;
                    end
                end
            end
            CMD_WR_CTRL:
            begin
                if (s1_data_reg[7:6] == 2'b00)
                begin
                    if (s1_data_reg[5:4] == ACC_LATCH)
                    begin
                        if (!latch_held_reg)
                        begin
                            latched_next    = count_reg;
                            latch_held_next = 1'b1;
                        end
                    end
                    else
                    begin
                        mode_next         = mode_decode(s1_data_reg[3:1]);
                        access_kind_next  = s1_data_reg[5:4];
                        write_toggle_next = 1'b0;
                        read_toggle_next  = 1'b0;
                        latch_held_next   = 1'b0;
                        running_next      = 1'b0;
                        out_pin_next      = (mode_next != MODE_ONESHOT);
                    end
                end
            end
            CMD_WR_COUNT:
            begin
                if (access_kind_reg == ACC_LO)
                begin
                    reload_next = {8'd0, s1_data_reg};
                    do_load     = 1'b1;
                end
                else if (access_kind_reg == ACC_HI)
                begin
                    reload_next = {s1_data_reg, 8'd0};
                    do_load     = 1'b1;
                end
                else if (!write_toggle_reg)
                begin
                    low_pending_next  = s1_data_reg;
                    write_toggle_next = 1'b1;
                    if (mode_reg != MODE_RATE && mode_reg != MODE_SQUARE)
                        running_next = 1'b0;
                end
                else
                begin
                    reload_next       = {s1_data_reg, low_pending_reg};
                    write_toggle_next = 1'b0;
                    do_load           = 1'b1;
                end
            end
            CMD_RD_COUNT:
            begin
                if (access_kind_reg == ACC_LO)
                begin
                    latch_held_next = 1'b0;
                    rd_byte         = rd_src[7:0];
                end
                else if (access_kind_reg == ACC_HI)
                begin
                    latch_held_next = 1'b0;
                    rd_byte         = rd_src[15:8];
                end
                else if (!read_toggle_reg)
                begin
                    read_toggle_next = 1'b1;
                    rd_byte          = rd_src[7:0];
                end
                else
                begin
                    read_toggle_next = 1'b0;
                    latch_held_next  = 1'b0;
                    rd_byte          = rd_src[15:8];
                end
            end
            default:
            begin
            end
        endcase

        if (do_load)
        begin
            if (mode_reg == MODE_RATE || mode_reg == MODE_SQUARE)
            begin
                if (!running_reg)
                begin
                    out_pin_next = 1'b1;
                    count_next   = (mode_reg == MODE_SQUARE) ?
                                   half_period_load(reload_next, 1'b1) : reload_next;
                    running_next = 1'b1;
                end
            end
            else
            begin
                count_next   = reload_next;
                out_pin_next = 1'b0;
                running_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (s1_fire)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            count_reg        <= '0;
            reload_reg       <= '0;
            mode_reg         <= MODE_ONESHOT;
            access_kind_reg  <= ACC_LOHI;
            low_pending_reg  <= '0;
            write_toggle_reg <= 1'b0;
            read_toggle_reg  <= 1'b0;
            latched_reg      <= '0;
            latch_held_reg   <= 1'b0;
            running_reg      <= 1'b0;
            out_pin_reg      <= 1'b1;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (s1_fire)
            begin
                count_reg        <= count_next;
                reload_reg       <= reload_next;
                mode_reg         <= mode_next;
                access_kind_reg  <= access_kind_next;
                low_pending_reg  <= low_pending_next;
                write_toggle_reg <= write_toggle_next;
                read_toggle_reg  <= read_toggle_next;
                latched_reg      <= latched_next;
                latch_held_reg   <= latch_held_next;
                running_reg      <= running_next;
                out_pin_reg      <= out_pin_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_cmd_reg  <= req.cmd;
            s1_data_reg <= req.data_byte;
        end
        if (s1_fire)
        begin
            rsp_read_byte_reg <= rd_byte;
            rsp_out_level_reg <= out_pin_next;
            rsp_count_reg     <= count_next;
        end
    end

    a_read_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_cmd_reg != CMD_RD_COUNT) |=> (rsp_read_byte_reg == '0))
        else $error("read_byte not zero for a beat that is not a read");

    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_cmd_reg == CMD_TICK && !running_reg) |=> $stable(count_reg))
        else $error("count moved on a tick while stopped");

    a_split_access: assert property (@(posedge clk) disable iff (!rst_n)
        (write_toggle_reg || read_toggle_reg) |-> (access_kind_reg == ACC_LOHI))
        else $error("byte flip-flop set outside low then high access");

    a_resp_matches: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (rsp_count_reg == count_reg && rsp_out_level_reg == out_pin_reg))
        else $error("response beat disagrees with the channel state");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval timer channel testbench
// Drives tick, command, count write and count read beats into the channel,
// predicts every response beat with a local model of the counter and compares
// each field. Runs a directed opening, then random timer programs under
// several idle and stall patterns and one long response hold.
// ----------------------------------------------------------------------------
module testbench;
    import itc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [1:0] CH_ZERO     = 2'd0;
    localparam logic [1:0] CH_ONE      = 2'd1;
    localparam logic [1:0] CH_TWO      = 2'd2;
    localparam logic [1:0] CH_READBACK = 2'd3;

    localparam logic [2:0] FIELD_MODE0 = 3'd0;
    localparam logic [2:0] FIELD_MODE1 = 3'd1;
    localparam logic [2:0] FIELD_MODE2 = 3'd2;
    localparam logic [2:0] FIELD_MODE3 = 3'd3;
    localparam logic [2:0] FIELD_MODE4 = 3'd4;
    localparam logic [2:0] FIELD_MODE5 = 3'd5;
    localparam logic [2:0] FIELD_MODE6 = 3'd6;
    localparam logic [2:0] FIELD_MODE7 = 3'd7;

    typedef struct packed {
        byte_t  read_byte;
        logic   out_level;
        count_t current_count;
    } timer_result_t;

    logic clk;
    logic rst_n;

    itc_req_if req_if ();
    itc_rsp_if rsp_if ();

    interval_timer_channel_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    timer_result_t expected_results[$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  beats_sent;
    int  fail_count;
    int  cycle_count;
    bit  hold_request;

    count_t cnt_elem;
    count_t reload_val;
    mode_t  cur_mode;
    acc_t   cur_acc;
    byte_t  low_hold;
    logic   wr_flip;
    logic   rd_flip;
    count_t snap_val;
    logic   snap_held;
    logic   counting;
    logic   out_q;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic byte_t make_ctrl(logic [1:0] ch, acc_t acc, logic [2:0] m, logic bcd);
        return {ch, acc, m, bcd};
    endfunction

    function automatic byte_t count_byte_value();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 12));
        return 8'($urandom_range(0, 255));
    endfunction

    // Start value of a square-wave half period for the given output level.
    function automatic count_t square_half_count(logic level);
        count_t n = reload_val;
        if (!n[0])
            return n;
        if (level)
            return n + COUNT_ONE;
        if (n == COUNT_ONE)
            return COUNT_TWO;
        return n - COUNT_ONE;
    endfunction

    task automatic load_counter();
        if (cur_mode == MODE_RATE || cur_mode == MODE_SQUARE)
        begin
            if (!counting)
            begin
                out_q    = 1'b1;
                cnt_elem = (cur_mode == MODE_SQUARE) ? square_half_count(1'b1) : reload_val;
                counting = 1'b1;
            end
        end
        else
        begin
            cnt_elem = reload_val;
            out_q    = 1'b0;
            counting = 1'b1;
        end
    endtask

    task automatic advance_timer(input cmd_t c, input byte_t d);
        timer_result_t r;
        count_t        src;
        r.read_byte = 8'h00;
        case (c)
            CMD_TICK:
            begin
                if (counting)
                begin
                    if (cur_mode == MODE_RATE)
                    begin
                        if (cnt_elem == COUNT_ONE)
                        begin
                            cnt_elem = reload_val;
                            out_q    = 1'b1;
                        end
                        else
                        begin
                            cnt_elem = cnt_elem - COUNT_ONE;
                            if (cnt_elem == COUNT_ONE)
                                out_q = 1'b0;
                        end
                    end
                    else if (cur_mode == MODE_SQUARE)
                    begin
                        if (cnt_elem == COUNT_TWO)
                        begin
                            out_q    = ~out_q;
                            cnt_elem = square_half_count(out_q);
                        end
                        else
                            cnt_elem = cnt_elem - COUNT_TWO;
                    end
                    else
                    begin
                        cnt_elem = cnt_elem - COUNT_ONE;
                        if (cnt_elem == 16'd0)
                            out_q = 1'b1;
                    end
                end
            end
            CMD_WR_CTRL:
            begin
                if (d[7:6] == CH_ZERO)
                begin
                    if (acc_t'(d[5:4]) == ACC_LATCH)
                    begin
                        if (!snap_held)
                        begin
                            snap_val  = cnt_elem;
                            snap_held = 1'b1;
                        end
                    end
                    else
                    begin
                        case (d[3:1])
                            FIELD_MODE2, FIELD_MODE6: cur_mode = MODE_RATE;
                            FIELD_MODE3, FIELD_MODE7: cur_mode = MODE_SQUARE;
                            default:                  cur_mode = MODE_ONESHOT;
                        endcase
                        cur_acc   = acc_t'(d[5:4]);
                        wr_flip   = 1'b0;
                        rd_flip   = 1'b0;
                        snap_held = 1'b0;
                        counting  = 1'b0;
                        out_q     = (cur_mode == MODE_ONESHOT) ? 1'b0 : 1'b1;
                    end
                end
            end
            CMD_WR_COUNT:
            begin
                if (cur_acc == ACC_LO)
                begin
                    reload_val = {8'h00, d};
                    load_counter();
                end
                else if (cur_acc == ACC_HI)
                begin
                    reload_val = {d, 8'h00};
                    load_counter();
                end
                else if (!wr_flip)
                begin
                    low_hold = d;
                    wr_flip  = 1'b1;
                    if (cur_mode != MODE_RATE && cur_mode != MODE_SQUARE)
                        counting = 1'b0;
                end
                else
                begin
                    reload_val = {d, low_hold};
                    wr_flip    = 1'b0;
                    load_counter();
                end
            end
            default:
            begin
                src = snap_held ? snap_val : cnt_elem;
                if (cur_acc == ACC_LO)
                begin
                    snap_held   = 1'b0;
                    r.read_byte = src[7:0];
                end
                else if (cur_acc == ACC_HI)
                begin
                    snap_held   = 1'b0;
                    r.read_byte = src[15:8];
                end
                else if (!rd_flip)
                begin
                    rd_flip     = 1'b1;
                    r.read_byte = src[7:0];
                end
                else
                begin
                    rd_flip     = 1'b0;
                    snap_held   = 1'b0;
                    r.read_byte = src[15:8];
                end
            end
        endcase
        r.out_level     = out_q;
        r.current_count = cnt_elem;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    task automatic send_beat(input cmd_t c, input byte_t d);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.cmd       <= c;
        req_if.data_byte <= d;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        advance_timer(c, d);
        beats_sent++;
    endtask

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            int hold_left;
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        timer_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("response beat with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_if.read_byte !== want.read_byte)
                        report_mismatch($sformatf("read_byte got %02h want %02h",
                                                  rsp_if.read_byte, want.read_byte));
                    if (rsp_if.out_level !== want.out_level)
                        report_mismatch($sformatf("out_level got %b want %b",
                                                  rsp_if.out_level, want.out_level));
                    if (rsp_if.current_count !== want.current_count)
                        report_mismatch($sformatf("current_count got %04h want %04h",
                                                  rsp_if.current_count, want.current_count));
                end
            end
        end
    end

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_beat(CMD_RD_COUNT, 8'h00);
        send_beat(CMD_TICK, 8'hFF);
        send_beat(CMD_WR_CTRL, make_ctrl(CH_READBACK, ACC_LOHI, FIELD_MODE0, 1'b1));
        send_beat(CMD_WR_CTRL, make_ctrl(CH_ONE, ACC_LO, FIELD_MODE2, 1'b0));
        send_beat(CMD_WR_CTRL, make_ctrl(CH_ZERO, ACC_LOHI, FIELD_MODE0, 1'b0));
        send_beat(CMD_WR_COUNT, 8'hFF);
        send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_WR_COUNT, 8'hFF);
        send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_WR_CTRL, make_ctrl(CH_ZERO, ACC_LATCH, FIELD_MODE0, 1'b0));
        send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_WR_CTRL, make_ctrl(CH_ZERO, ACC_LATCH, FIELD_MODE7, 1'b1));
        send_beat(CMD_RD_COUNT, 8'hFF);
        send_beat(CMD_RD_COUNT, 8'h00);
        send_beat(CMD_WR_CTRL, make_ctrl(CH_ZERO, ACC_LO, FIELD_MODE2, 1'b0));
        send_beat(CMD_WR_COUNT, 8'h01);
        repeat (2) send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_WR_CTRL, make_ctrl(CH_ZERO, ACC_LO, FIELD_MODE7, 1'b0));
        send_beat(CMD_WR_COUNT, 8'h01);
        repeat (2) send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_WR_CTRL, make_ctrl(CH_ZERO, ACC_LO, FIELD_MODE3, 1'b1));
        send_beat(CMD_WR_COUNT, 8'h03);
        repeat (4) send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_WR_CTRL, make_ctrl(CH_ZERO, ACC_HI, FIELD_MODE5, 1'b1));
        send_beat(CMD_WR_COUNT, 8'h00);
        send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_WR_CTRL, make_ctrl(CH_ZERO, ACC_LO, FIELD_MODE1, 1'b0));
        send_beat(CMD_WR_COUNT, 8'h02);
        repeat (3) send_beat(CMD_TICK, 8'h00);
        send_beat(CMD_WR_CTRL, make_ctrl(CH_TWO, ACC_HI, FIELD_MODE4, 1'b0));
    endtask

    task automatic run_timer_program();
        acc_t acc;
        int   steps;
        int   pick;
        acc = acc_t'($urandom_range(ACC_LO, ACC_LOHI));
        send_beat(CMD_WR_CTRL, make_ctrl(CH_ZERO, acc, 3'($urandom_range(FIELD_MODE0, FIELD_MODE7)),
                                         1'($urandom_range(0, 1))));
        send_beat(CMD_WR_COUNT, count_byte_value());
        if (acc == ACC_LOHI)
            send_beat(CMD_WR_COUNT,
                      ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00);
        steps = $urandom_range(4, 40);
        repeat (steps)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_beat(CMD_TICK, 8'($urandom));
            else if (pick < 80)
                send_beat(CMD_RD_COUNT, 8'($urandom));
            else if (pick < 85)
                send_beat(CMD_WR_CTRL, make_ctrl(CH_ZERO, ACC_LATCH, 3'($urandom),
                                                 1'($urandom)));
            else if (pick < 92)
                send_beat(CMD_WR_COUNT, count_byte_value());
            else
                send_beat(cmd_t'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_random_programs(input int idle_pct, input int stall_pct,
                                        input int n_items);
        int target;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = beats_sent + n_items;
        while (beats_sent < target)
            run_timer_program();
    endtask

    // The response side is held off while beats keep coming, so that the
    // channel fills and stalls its request side.
    task automatic test_response_hold();
        hold_request = 1'b1;
        test_random_programs(0, 0, 100);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.cmd       = CMD_TICK;
        req_if.data_byte = 8'h00;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        beats_sent       = 0;
        fail_count       = 0;
        hold_request     = 1'b0;

        cnt_elem   = 16'd0;
        reload_val = 16'd0;
        cur_mode   = MODE_ONESHOT;
        cur_acc    = ACC_LOHI;
        low_hold   = 8'h00;
        wr_flip    = 1'b0;
        rd_flip    = 1'b0;
        snap_val   = 16'd0;
        snap_held  = 1'b0;
        counting   = 1'b0;
        out_q      = 1'b1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_programs(0, 0, 380);
        test_random_programs(75, 0, 400);
        test_random_programs(0, 75, 400);
        test_random_programs(13, 13, 400);
        test_response_hold();

        req_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: interval_timer_channel_top.f
hdl/itc_pkg.sv
hdl/itc_if.sv
hdl/interval_timer_channel_top.sv
bench/testbench.sv
